[hdl/pmcsd_pkg.sv]
`default_nettype none

package pmcsd_pkg;

  localparam int unsigned MaxResults = 6;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [28:0] BASE_ID  = 29'h6D0;
  localparam logic [25:0] BASE_BLK = BASE_ID[28:3];

  localparam logic [2:0] OFF_INPUT  = 3'd3;
  localparam logic [2:0] OFF_OUTPUT = 3'd4;
  localparam logic [2:0] OFF_DEVICE = 3'd5;

  localparam logic [2:0] IO_25A    = 3'd0;
  localparam logic [2:0] IO_8A     = 3'd1;
  localparam logic [2:0] IO_SPEED  = 3'd3;
  localparam logic [2:0] IO_ANALOG = 3'd4;

  localparam logic [3:0] K_STATUS   = 4'd0;
  localparam logic [3:0] K_FIRMWARE = 4'd1;
  localparam logic [3:0] K_LOAD     = 4'd2;
  localparam logic [3:0] K_VOLTAGE  = 4'd3;
  localparam logic [3:0] K_CUR_LOW  = 4'd4;
  localparam logic [3:0] K_CUR_HIGH = 4'd5;
  localparam logic [3:0] K_RETRIES  = 4'd6;
  localparam logic [3:0] K_PIN      = 4'd7;
  localparam logic [3:0] K_CURRENT  = 4'd8;
  localparam logic [3:0] K_STATE    = 4'd9;
  localparam logic [3:0] K_DUTY     = 4'd10;
  localparam logic [3:0] K_FREQ     = 4'd11;

  typedef struct packed {
    logic [28:0]     id;
    logic            ok;
    logic [3:0]      len;
    logic [7:0][7:0] bytes;
  } frame_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  io_kind;
    logic [3:0]  io_number;
    logic [15:0] value;
  } entry_t;

  typedef struct packed {
    logic                           valid;
    logic [CntW-1:0]                count;
    entry_t [MaxResults-1:0]        entries;
  } list_t;

  typedef struct packed {
    logic            list_valid;
    logic [CntW-1:0] idx;
    logic [CntW-1:0] count;
  } emit_status_t;

endpackage

`default_nettype wire

[hdl/pmcsd_if.sv]
`default_nettype none

interface pmcsd_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic        frame_ok;
  logic [3:0]  payload_length;
  logic [7:0]  payload_byte_0;
  logic [7:0]  payload_byte_1;
  logic [7:0]  payload_byte_2;
  logic [7:0]  payload_byte_3;
  logic [7:0]  payload_byte_4;
  logic [7:0]  payload_byte_5;
  logic [7:0]  payload_byte_6;
  logic [7:0]  payload_byte_7;

  modport source (
    output valid, frame_id, frame_ok, payload_length,
    output payload_byte_0, payload_byte_1, payload_byte_2, payload_byte_3,
    output payload_byte_4, payload_byte_5, payload_byte_6, payload_byte_7,
    input  ready
  );
  modport sink (
    input  valid, frame_id, frame_ok, payload_length,
    input  payload_byte_0, payload_byte_1, payload_byte_2, payload_byte_3,
    input  payload_byte_4, payload_byte_5, payload_byte_6, payload_byte_7,
    output ready
  );
endinterface

interface pmcsd_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel_kind;
  logic [2:0]  io_kind;
  logic [3:0]  io_number;
  logic [15:0] raw_value;
  logic        last_of_frame;

  modport source (
    output valid, channel_kind, io_kind, io_number, raw_value, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, channel_kind, io_kind, io_number, raw_value, last_of_frame,
    output ready
  );
endinterface

interface pmcsd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] device_select;

  modport source (output valid, device_select, input ready);
  modport sink (input valid, device_select, output ready);
endinterface

`default_nettype wire

[hdl/pmcsd_decode.sv]
`default_nettype none

module pmcsd_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [2:0]        device_select,
  input  wire logic              in_valid,
  input  wire pmcsd_pkg::frame_t in_frame,
  output logic                   in_ready,
  output pmcsd_pkg::list_t       list,
  input  wire logic              list_take
);

  logic              fr_valid;
  pmcsd_pkg::frame_t fr;

  logic [pmcsd_pkg::CntW-1:0]   n;
  pmcsd_pkg::entry_t [pmcsd_pkg::MaxResults-1:0] ents;
  logic [2:0]  typ;
  logic [3:0]  idx;
  logic        hit;
  logic [15:0] fw;
  logic [7:0]  b0, b1, b2, b3, b4, b5, b6, b7;
  logic [3:0]  len;

  assign in_ready = !fr_valid || list_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_ready) begin
      fr_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      fr <= in_frame;
    end
  end

  always_comb begin
    b0  = fr.bytes[0];
    b1  = fr.bytes[1];
    b2  = fr.bytes[2];
    b3  = fr.bytes[3];
    b4  = fr.bytes[4];
    b5  = fr.bytes[5];
    b6  = fr.bytes[6];
    b7  = fr.bytes[7];
    len = fr.len;
    typ = b0[7:5];
    idx = b0[3:0];
    fw  = 16'(b1[1:0]) * 16'd10000 + 16'(b2) * 16'd100 + 16'(b3);
    hit = fr.ok && (len != 4'd0) &&
          (fr.id[28:3] == pmcsd_pkg::BASE_BLK + 26'(device_select));
    n    = '0;
    ents = '0;
    if (hit) begin
      unique case (fr.id[2:0])
        pmcsd_pkg::OFF_INPUT: begin
          if (len >= 4'd2 && (typ == pmcsd_pkg::IO_SPEED || typ == pmcsd_pkg::IO_ANALOG)) begin
            ents[n] = '{pmcsd_pkg::K_STATE, typ, idx, {15'd0, b1[0]}};
            n = n + 1'b1;
            if (len >= 4'd4) begin
              ents[n] = '{pmcsd_pkg::K_VOLTAGE, typ, idx, {b2, b3}};
              n = n + 1'b1;
            end
            if (typ == pmcsd_pkg::IO_SPEED && len >= 4'd6) begin
              ents[n] = '{pmcsd_pkg::K_DUTY, typ, idx, {b4, b5}};
              n = n + 1'b1;
            end
            if (typ == pmcsd_pkg::IO_SPEED && len >= 4'd8) begin
              ents[n] = '{pmcsd_pkg::K_FREQ, typ, idx, {b6, b7}};
              n = n + 1'b1;
            end
          end
        end
        pmcsd_pkg::OFF_OUTPUT: begin
          if (len >= 4'd2 && typ == pmcsd_pkg::IO_25A) begin
            ents[n] = '{pmcsd_pkg::K_LOAD, typ, idx, {8'd0, b1}};
            n = n + 1'b1;
            if (len >= 4'd4) begin
              ents[n] = '{pmcsd_pkg::K_VOLTAGE, typ, idx, {b2, b3}};
              n = n + 1'b1;
            end
            if (len >= 4'd6) begin
              ents[n] = '{pmcsd_pkg::K_CUR_LOW, typ, idx, {b4, b5}};
              n = n + 1'b1;
            end
            if (len >= 4'd7) begin
              ents[n] = '{pmcsd_pkg::K_CUR_HIGH, typ, idx, {8'd0, b6}};
              n = n + 1'b1;
            end
            if (len >= 4'd8) begin
              ents[n] = '{pmcsd_pkg::K_RETRIES, typ, idx, {12'd0, b7[7:4]}};
              n = n + 1'b1;
              ents[n] = '{pmcsd_pkg::K_PIN, typ, idx, {12'd0, b7[3:0]}};
              n = n + 1'b1;
            end
          end else if (len >= 4'd2 && typ == pmcsd_pkg::IO_8A) begin
            ents[n] = '{pmcsd_pkg::K_RETRIES, typ, idx, {11'd0, b1[7:3]}};
            n = n + 1'b1;
            ents[n] = '{pmcsd_pkg::K_PIN, typ, idx, {13'd0, b1[2:0]}};
            n = n + 1'b1;
            if (len >= 4'd4) begin
              ents[n] = '{pmcsd_pkg::K_VOLTAGE, typ, idx, {b2, b3}};
              n = n + 1'b1;
            end
            if (len >= 4'd6) begin
              ents[n] = '{pmcsd_pkg::K_CURRENT, typ, idx, {b4, b5}};
              n = n + 1'b1;
            end
            if (len >= 4'd7) begin
              ents[n] = '{pmcsd_pkg::K_LOAD, typ, idx, {8'd0, b6}};
              n = n + 1'b1;
            end
          end
        end
        pmcsd_pkg::OFF_DEVICE: begin
          if (len >= 4'd5) begin
            ents[n] = '{pmcsd_pkg::K_STATUS, 3'd0, 4'd0, {12'd0, b0[7:4]}};
            n = n + 1'b1;
            ents[n] = '{pmcsd_pkg::K_FIRMWARE, 3'd0, 4'd0, fw};
            n = n + 1'b1;
          end
        end
        default: begin
          n = '0;
        end
      endcase
    end
  end

  assign list.valid   = fr_valid;
  assign list.count   = n;
  assign list.entries = ents;

endmodule

`default_nettype wire

[hdl/pmcsd_emit.sv]
`default_nettype none

module pmcsd_emit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pmcsd_pkg::list_t       list_in,
  output logic                        list_take,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output pmcsd_pkg::entry_t           out_entry,
  output logic                        out_last,
  output pmcsd_pkg::emit_status_t     status
);

  logic                       lv;
  logic [pmcsd_pkg::CntW-1:0] cnt;
  logic [pmcsd_pkg::CntW-1:0] idx;
  pmcsd_pkg::entry_t [pmcsd_pkg::MaxResults-1:0] ents;

  logic pop;
  logic last;
  logic list_free;

  assign pop       = lv && (!out_valid || out_ready);
  assign last      = (idx == cnt - 1'b1);
  assign list_free = !lv || (pop && last);
  assign list_take = list_in.valid && list_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      lv <= 1'b0;
    end else if (list_take) begin
      lv <= (list_in.count != '0);
    end else if (pop && last) begin
      lv <= 1'b0;
    end
    if (list_take) begin
      cnt  <= list_in.count;
      ents <= list_in.entries;
      idx  <= '0;
    end else if (pop) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop) begin
      out_entry <= ents[idx];
      out_last  <= last;
    end
  end

  assign status.list_valid = lv;
  assign status.idx        = idx;
  assign status.count      = cnt;

endmodule

`default_nettype wire

[hdl/power_module_can_status_decoder.sv]
// Power module CAN status decoder.
// frame: one CAN frame per item (identifier, valid flag, length, eight bytes).
// result: one channel item per cycle while result.ready is high. A frame's
//   last item has last_of_frame set; frames decoding to nothing yield none.
// cfg: device_select write channel, always ready; write it only while idle.
// Path: an accepted frame goes through the frame register, then the decoded
//   list register, then the output register that drives result.
// Throughput: one result per cycle while result.ready is high; a frame holds
//   the emitter until all of its results (up to six) are out.
//   The next frame is taken and decoded while the current one drains.
// Reset (synchronous, active high) empties all stages and sets device_select
//   to zero.
// When result.ready is low the output item holds, the emitter stops, and
//   frame.ready drops once the frame register is full.
`default_nettype none

module power_module_can_status_decoder (
  input  wire logic     clk,
  input  wire logic     rst,
  pmcsd_frame_if.sink   frame,
  pmcsd_result_if.source result,
  pmcsd_cfg_if.sink     cfg
);

  logic [2:0]                  device_select;
  pmcsd_pkg::frame_t           in_frame;
  pmcsd_pkg::list_t            list;
  logic                        list_take;
  pmcsd_pkg::entry_t           out_entry;
  logic                        out_last;
  pmcsd_pkg::emit_status_t     st;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_select <= 3'd0;
    end else if (cfg.valid) begin
      device_select <= cfg.device_select;
    end
  end

  assign in_frame.id       = frame.frame_id;
  assign in_frame.ok       = frame.frame_ok;
  assign in_frame.len      = frame.payload_length;
  assign in_frame.bytes[0] = frame.payload_byte_0;
  assign in_frame.bytes[1] = frame.payload_byte_1;
  assign in_frame.bytes[2] = frame.payload_byte_2;
  assign in_frame.bytes[3] = frame.payload_byte_3;
  assign in_frame.bytes[4] = frame.payload_byte_4;
  assign in_frame.bytes[5] = frame.payload_byte_5;
  assign in_frame.bytes[6] = frame.payload_byte_6;
  assign in_frame.bytes[7] = frame.payload_byte_7;

  pmcsd_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .device_select (device_select),
    .in_valid      (frame.valid),
    .in_frame      (in_frame),
    .in_ready      (frame.ready),
    .list          (list),
    .list_take     (list_take)
  );

  pmcsd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .list_in   (list),
    .list_take (list_take),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_entry (out_entry),
    .out_last  (out_last),
    .status    (st)
  );

  assign result.channel_kind  = out_entry.kind;
  assign result.io_kind       = out_entry.io_kind;
  assign result.io_number     = out_entry.io_number;
  assign result.raw_value     = out_entry.value;
  assign result.last_of_frame = out_last;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    st.list_valid |-> (st.idx < st.count))
    else $error("emit index past list count");

  a_no_empty_list: assert property (@(posedge clk) disable iff (rst)
    st.list_valid |-> (st.count != '0))
    else $error("empty list held in emitter");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!result.valid && !st.list_valid))
    else $error("stages not empty after reset");

  a_take_needs_frame: assert property (@(posedge clk) disable iff (rst)
    list_take |-> !frame.ready || list.valid)
    else $error("list taken without a decoded frame");

endmodule

`default_nettype wire
